// File: rtl/core/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// DTMF package
// Shared constants, types and the quarter-wave sine table of the DTMF tone
// generator.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	// Oscillator geometry.
	localparam int PHASE_ENTRIES = 1024;
	localparam int SAMPLE_BITS   = 8;
	localparam int PHASE_BITS    = $clog2(PHASE_ENTRIES);
	localparam int QUARTER       = PHASE_ENTRIES / 4;
	localparam int QUARTER_BITS  = PHASE_BITS - 2;
	localparam int AMP           = 1 << (SAMPLE_BITS - 3);
	localparam int MAG_BITS      = $clog2(AMP + 1);
	localparam int MID           = 1 << (SAMPLE_BITS - 1);

	// Sample rate register and derived lengths.
	localparam int RATE_BITS   = 16;
	localparam int RATE_RESET  = 11025;
	// floor(x / 10) = (x * TENTH_MUL) >> TENTH_SHIFT for every 16-bit x.
	localparam int TENTH_MUL   = 52429;
	localparam int TENTH_SHIFT = 19;
	localparam int LEFT_BITS   = 2 * RATE_BITS - TENTH_SHIFT;

	// Phase step division: (f * PHASE_ENTRIES) / sample_rate.
	localparam int FREQ_BITS     = 11;
	localparam int DIVIDEND_BITS = FREQ_BITS + PHASE_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

	// Keypad.
	localparam int KEYS     = 16;
	localparam int POS_BITS = $clog2(KEYS);

	// Command queue between front and back.
	localparam int CMD_FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS  = $clog2(CMD_FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(CMD_FIFO_DEPTH + 1);

	// Play modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_TONE = 2'd1;
	localparam logic [1:0] MODE_GAP  = 2'd2;

	// Classified command codes.
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_KEY     = 2'd1;
	localparam logic [1:0] OP_BAD_KEY = 2'd2;

	typedef logic [7:0] keypad_t [KEYS];
	typedef logic [FREQ_BITS-1:0] freq_tab_t [4];
	typedef logic [8:0] taylor_tab_t [8];
	typedef logic [MAG_BITS-1:0] quarter_tab_t [QUARTER];

	// Keypad in scan order "123A456B789C*0#D".
	localparam keypad_t KEYPAD = '{
		8'h31, 8'h32, 8'h33, 8'h41,
		8'h34, 8'h35, 8'h36, 8'h42,
		8'h37, 8'h38, 8'h39, 8'h43,
		8'h2A, 8'h30, 8'h23, 8'h44
	};

	localparam freq_tab_t COL_FREQ = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};
	localparam freq_tab_t ROW_FREQ = '{11'd697, 11'd770, 11'd852, 11'd941};

	// Divisors of the nested Taylor evaluation of sin(x).
	localparam taylor_tab_t TAYLOR_DIV = '{
		9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
	};

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q40 = 64'd1727108826179;

	// One command as it travels from the front to the back.
	typedef struct packed {
		logic [1:0]          op;
		logic [POS_BITS-1:0] pos;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
		logic                   key_error;
		logic                   key_busy;
		logic                   active;
	} result_t;

	// Divider request and response.
	typedef struct packed {
		logic                     start;
		logic [DIVIDEND_BITS-1:0] dividend;
		logic [RATE_BITS-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [PHASE_BITS-1:0] quotient;
	} div_rsp_t;

	// Magnitude of trunc(AMP * sin(pi/2 * r / PHASE_ENTRIES)) in Q30 fixed
	// point. Evaluated only while the constant table is elaborated.
	function automatic logic [MAG_BITS-1:0] quarter_mag(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] m;
		if (r == 64'd0) begin
			m = 64'd0;
		end else if (r >= 64'(PHASE_ENTRIES)) begin
			m = 64'(AMP);
		end else if (64'd3 * r == 64'(PHASE_ENTRIES)) begin
			m = 64'(AMP / 2);
		end else begin
			x  = (r * HALF_PI_Q40) / 64'(PHASE_ENTRIES);
			x  = (x + 64'd512) >> 10;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			for (int k = 0; k < 8; k++) begin
				t = Q30_ONE - (((x2 * t) >> 30) / 64'(TAYLOR_DIV[k]));
			end
			s = (x * t) >> 30;
			if (s > Q30_ONE) begin
				s = Q30_ONE;
			end
			m = (64'(AMP) * s) >> 30;
		end
		return m[MAG_BITS-1:0];
	endfunction

	// First quadrant of the sine table; the peak point is handled by the reader.
	function automatic quarter_tab_t build_quarter_tab();
		quarter_tab_t tab;
		for (int j = 0; j < QUARTER; j++) begin
			tab[j] = quarter_mag(64'(j) * 64'(PHASE_ENTRIES / QUARTER));
		end
		return tab;
	endfunction

	localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();

endpackage

// File: rtl/core/dtmf_tone_generator_top.sv
// An accepted item passes the front stage register and the command queue before the back
// end registers its result. Throughput: one tick item per cycle while no division runs
// and the result side pops; a started key holds the back end while the shared bit-serial
// divider computes column and row steps, 21 steps each, while four items queue in between.
// Reset: arst_n clears all control state at once; sample_rate returns to 11025 and the
// generator is idle. No clearing pass: the sine table is constant logic.
// ----------------------------------------------------------------------------
// DTMF tone generator
// Table-driven two-oscillator DTMF generator with a classifying front end,
// a command queue and a back end that plays tone and gap samples.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                command,
	input  logic [7:0]                          key_char,
	output logic                                empty,
	input  logic                                pop,
	output logic [dtmf_pkg::SAMPLE_BITS-1:0]    sample,
	output logic                                sample_valid,
	output logic                                key_error,
	output logic                                key_busy,
	output logic                                active,
	input  logic                                cfg_wr_en,
	input  logic [dtmf_pkg::RATE_BITS-1:0]      cfg_wr_data
);

	logic               q_push;
	dtmf_pkg::cmd_t     q_wr_cmd;
	logic               q_full;
	logic               q_pop;
	dtmf_pkg::cmd_t     q_rd_cmd;
	logic               q_empty;
	dtmf_pkg::div_req_t div_req;
	dtmf_pkg::div_rsp_t div_rsp;
	dtmf_pkg::result_t  res;

	// Front end: accept and classify.
	dtmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.key_char  (key_char),
		.fifo_push (q_push),
		.fifo_cmd  (q_wr_cmd),
		.fifo_full (q_full)
	);

	// Command queue.
	dtmf_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	// Phase step divider.
	dtmf_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Back end: play and report.
	dtmf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fifo_empty  (q_empty),
		.fifo_cmd    (q_rd_cmd),
		.fifo_pop    (q_pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.res         (res),
		.res_empty   (empty),
		.res_pop     (pop)
	);

	assign sample       = res.sample;
	assign sample_valid = res.sample_valid;
	assign key_error    = res.key_error;
	assign key_busy     = res.key_busy;
	assign active       = res.active;

endmodule

// File: rtl/core/dtmf_front.sv
// ----------------------------------------------------------------------------
// DTMF front end
// Accepts input items, matches key characters against the keypad and passes
// classified commands to the command queue through one register stage.
// ----------------------------------------------------------------------------
module dtmf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           command,
	input  logic [7:0]     key_char,
	output logic           fifo_push,
	output dtmf_pkg::cmd_t fifo_cmd,
	input  logic           fifo_full
);

	logic           valid_s1;
	dtmf_pkg::cmd_t cmd_s1;
	dtmf_pkg::cmd_t cmd_class;
	logic           accept;
	logic           forward;
	logic [7:0]     upper_char;
	logic           hit;
	logic [dtmf_pkg::POS_BITS-1:0] hit_pos;

	// Upper-case the character, then search the keypad; first match wins.
	always_comb begin
		if (key_char >= 8'h61 && key_char <= 8'h7A) begin
			upper_char = key_char - 8'd32;
		end else begin
			upper_char = key_char;
		end
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = dtmf_pkg::KEYS - 1; i >= 0; i--) begin
			if (dtmf_pkg::KEYPAD[i] == upper_char) begin
				hit     = 1'b1;
				hit_pos = dtmf_pkg::POS_BITS'(i);
			end
		end
	end

	// Classify the incoming item.
	always_comb begin
		cmd_class.pos = '0;
		if (command) begin
			cmd_class.op = dtmf_pkg::OP_TICK;
		end else if (hit) begin
			cmd_class.op  = dtmf_pkg::OP_KEY;
			cmd_class.pos = hit_pos;
		end else begin
			cmd_class.op = dtmf_pkg::OP_BAD_KEY;
		end
	end

	// Stage handshake: the stage drains into the queue whenever it has room.
	assign forward   = valid_s1 && !fifo_full;
	assign full      = valid_s1 && fifo_full;
	assign accept    = push && !full;
	assign fifo_push = forward;
	assign fifo_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (forward) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_class;
		end
	end

endmodule

// File: rtl/core/dtmf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// DTMF command queue
// Short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module dtmf_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtmf_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output dtmf_pkg::cmd_t rd_cmd,
	output logic           empty
);

	dtmf_pkg::cmd_t                      entry_q [dtmf_pkg::CMD_FIFO_DEPTH];
	logic [dtmf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [dtmf_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [dtmf_pkg::FIFO_CNT_BITS-1:0] count_q;
	logic                                do_push;
	logic                                do_pop;

	assign full    = (count_q == dtmf_pkg::FIFO_CNT_BITS'(dtmf_pkg::CMD_FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == dtmf_pkg::FIFO_PTR_BITS'(dtmf_pkg::CMD_FIFO_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == dtmf_pkg::FIFO_PTR_BITS'(dtmf_pkg::CMD_FIFO_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

`ifndef SYNTHESIS
	// The front end never offers an item to a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into full queue");

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dtmf_pkg::FIFO_CNT_BITS'(dtmf_pkg::CMD_FIFO_DEPTH))
		else $error("command queue count out of range");
`endif

endmodule

// File: rtl/core/dtmf_divider.sv
// ----------------------------------------------------------------------------
// DTMF phase step divider
// Restoring divider, one quotient bit per cycle, that returns the low phase
// bits of (frequency * PHASE_ENTRIES) / sample_rate.
// ----------------------------------------------------------------------------
module dtmf_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  dtmf_pkg::div_req_t req,
	output dtmf_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [dtmf_pkg::DIV_CNT_BITS-1:0]  cnt_q;
	logic [dtmf_pkg::DIVIDEND_BITS-1:0] num_q;
	logic [dtmf_pkg::RATE_BITS-1:0]     den_q;
	logic [dtmf_pkg::RATE_BITS-1:0]     rem_q;
	logic [dtmf_pkg::PHASE_BITS-1:0]    quot_q;
	logic [dtmf_pkg::RATE_BITS:0]       trial;
	logic [dtmf_pkg::RATE_BITS:0]       diff;
	logic                                fits;
	logic [dtmf_pkg::RATE_BITS-1:0]     rem_next;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial    = {rem_q, num_q[dtmf_pkg::DIVIDEND_BITS-1]};
		diff     = trial - {1'b0, den_q};
		fits     = (trial >= {1'b0, den_q});
		rem_next = fits ? diff[dtmf_pkg::RATE_BITS-1:0] : trial[dtmf_pkg::RATE_BITS-1:0];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == dtmf_pkg::DIV_CNT_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= dtmf_pkg::DIV_CNT_BITS'(dtmf_pkg::DIVIDEND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dtmf_pkg::DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath; only the low quotient bits are kept, the phase wraps anyway.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[dtmf_pkg::DIVIDEND_BITS-2:0], 1'b0};
			rem_q  <= rem_next;
			quot_q <= {quot_q[dtmf_pkg::PHASE_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

`ifndef SYNTHESIS
	// A new division never starts on top of one in flight.
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");
`endif

endmodule

// File: rtl/core/dtmf_back.sv
// ----------------------------------------------------------------------------
// DTMF back end
// Executes classified commands: starts keys, plays tone and gap samples from
// two phase accumulators, and holds each result in an output register.
// ----------------------------------------------------------------------------
module dtmf_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [dtmf_pkg::RATE_BITS-1:0]    cfg_wr_data,
	input  logic                              fifo_empty,
	input  dtmf_pkg::cmd_t                    fifo_cmd,
	output logic                              fifo_pop,
	output dtmf_pkg::div_req_t                div_req,
	input  dtmf_pkg::div_rsp_t                div_rsp,
	output dtmf_pkg::result_t                 res,
	output logic                              res_empty,
	input  logic                              res_pop
);

	// Sequencer states.
	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_DIV_COL = 2'd1;
	localparam logic [1:0] ST_DIV_ROW = 2'd2;

	logic [1:0]                              state_q;
	logic [dtmf_pkg::RATE_BITS-1:0]          rate_q;
	logic [1:0]                              mode_q;
	logic [1:0]                              mode_d;
	logic [dtmf_pkg::LEFT_BITS-1:0]          left_q;
	logic [dtmf_pkg::LEFT_BITS-1:0]          left_d;
	logic [dtmf_pkg::LEFT_BITS-1:0]          left_dec;
	logic [dtmf_pkg::PHASE_BITS-1:0]         col_phase_q;
	logic [dtmf_pkg::PHASE_BITS-1:0]         row_phase_q;
	logic [dtmf_pkg::PHASE_BITS-1:0]         col_phase_d;
	logic [dtmf_pkg::PHASE_BITS-1:0]         row_phase_d;
	logic [dtmf_pkg::PHASE_BITS-1:0]         col_step_q;
	logic [dtmf_pkg::PHASE_BITS-1:0]         row_step_q;
	logic [1:0]                              row_idx_q;
	logic                                    res_valid_q;
	dtmf_pkg::result_t                       res_q;
	dtmf_pkg::result_t                       res_d;
	logic                                    cmd_take;
	logic                                    key_start;
	logic                                    busy;
	logic                                    rate_zero;
	logic [2*dtmf_pkg::RATE_BITS-1:0]        rate_prod;
	logic [dtmf_pkg::LEFT_BITS-1:0]          tone_len;
	logic [dtmf_pkg::LEFT_BITS-1:0]          gap_len;
	logic [dtmf_pkg::SAMPLE_BITS-1:0]        tone_sample;

	// Signed sine value of one phase, folded from the first-quadrant table.
	function automatic logic [dtmf_pkg::SAMPLE_BITS-1:0] sine_term(
		input logic [dtmf_pkg::PHASE_BITS-1:0] ph
	);
		logic [dtmf_pkg::QUARTER_BITS:0]   j;
		logic [dtmf_pkg::MAG_BITS-1:0]     mag;
		logic [dtmf_pkg::SAMPLE_BITS-1:0]  ext;
		if (ph[dtmf_pkg::PHASE_BITS-2]) begin
			j = (dtmf_pkg::QUARTER_BITS + 1)'(dtmf_pkg::QUARTER)
				- {1'b0, ph[dtmf_pkg::QUARTER_BITS-1:0]};
		end else begin
			j = {1'b0, ph[dtmf_pkg::QUARTER_BITS-1:0]};
		end
		if (j[dtmf_pkg::QUARTER_BITS]) begin
			mag = dtmf_pkg::MAG_BITS'(dtmf_pkg::AMP);
		end else begin
			mag = dtmf_pkg::QUARTER_TAB[j[dtmf_pkg::QUARTER_BITS-1:0]];
		end
		ext = dtmf_pkg::SAMPLE_BITS'(mag);
		return ph[dtmf_pkg::PHASE_BITS-1] ? -ext : ext;
	endfunction

	// Tone length is rate/10 by reciprocal multiply; the gap is half of it.
	assign rate_prod = rate_q * dtmf_pkg::RATE_BITS'(dtmf_pkg::TENTH_MUL);
	assign tone_len  = rate_prod[dtmf_pkg::TENTH_SHIFT +: dtmf_pkg::LEFT_BITS];
	assign gap_len   = {1'b0, rate_prod[dtmf_pkg::TENTH_SHIFT+1 +: dtmf_pkg::LEFT_BITS-1]};
	assign rate_zero = (rate_q == '0);

	assign tone_sample = dtmf_pkg::SAMPLE_BITS'(dtmf_pkg::MID)
		+ sine_term(col_phase_q) + sine_term(row_phase_q);

	// A command is taken when no division runs and the result slot frees up.
	assign cmd_take = (state_q == ST_RUN) && !fifo_empty && (!res_valid_q || res_pop);
	assign fifo_pop = cmd_take;
	assign busy     = (mode_q != dtmf_pkg::MODE_IDLE);
	assign left_dec = left_q - 1'b1;

	// Next play state and result of the command at the head of the queue.
	always_comb begin
		mode_d      = mode_q;
		left_d      = left_q;
		col_phase_d = col_phase_q;
		row_phase_d = row_phase_q;
		key_start   = 1'b0;
		res_d       = '0;
		case (fifo_cmd.op)
			dtmf_pkg::OP_TICK: begin
				res_d.sample_valid = 1'b1;
				case (mode_q)
					dtmf_pkg::MODE_TONE: begin
						res_d.sample = tone_sample;
						col_phase_d  = col_phase_q + col_step_q;
						row_phase_d  = row_phase_q + row_step_q;
						left_d       = left_dec;
						if (left_dec == '0) begin
							left_d = gap_len;
							mode_d = (gap_len != '0) ? dtmf_pkg::MODE_GAP : dtmf_pkg::MODE_IDLE;
						end
					end
					dtmf_pkg::MODE_GAP: begin
						left_d = left_dec;
						if (left_dec == '0) begin
							mode_d = dtmf_pkg::MODE_IDLE;
						end
					end
					default: begin
						mode_d = dtmf_pkg::MODE_IDLE;
					end
				endcase
			end
			dtmf_pkg::OP_KEY: begin
				res_d.key_busy = busy;
				if (!busy) begin
					key_start   = 1'b1;
					col_phase_d = '0;
					row_phase_d = '0;
					if (tone_len != '0) begin
						left_d = tone_len;
						mode_d = dtmf_pkg::MODE_TONE;
					end else begin
						left_d = gap_len;
						mode_d = (gap_len != '0) ? dtmf_pkg::MODE_GAP : dtmf_pkg::MODE_IDLE;
					end
				end
			end
			dtmf_pkg::OP_BAD_KEY: begin
				res_d.key_error = 1'b1;
				res_d.key_busy  = busy;
			end
			default: begin
				res_d = '0;
			end
		endcase
		res_d.active = (mode_d != dtmf_pkg::MODE_IDLE);
	end

	// Divider requests: column step at key start, row step after it.
	always_comb begin
		div_req.divisor = rate_q;
		if (state_q == ST_DIV_COL) begin
			div_req.start    = div_rsp.done;
			div_req.dividend = {dtmf_pkg::ROW_FREQ[row_idx_q], dtmf_pkg::PHASE_BITS'(0)};
		end else begin
			div_req.start    = cmd_take && key_start && !rate_zero;
			div_req.dividend = {dtmf_pkg::COL_FREQ[fifo_cmd.pos[1:0]],
				dtmf_pkg::PHASE_BITS'(0)};
		end
	end

	// Sequencer, play state, configuration register and output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			rate_q      <= dtmf_pkg::RATE_BITS'(dtmf_pkg::RATE_RESET);
			mode_q      <= dtmf_pkg::MODE_IDLE;
			left_q      <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			col_step_q  <= '0;
			row_step_q  <= '0;
			row_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (cmd_take) begin
				mode_q      <= mode_d;
				left_q      <= left_d;
				col_phase_q <= col_phase_d;
				row_phase_q <= row_phase_d;
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (cmd_take && key_start) begin
						row_idx_q <= fifo_cmd.pos[3:2];
						if (rate_zero) begin
							col_step_q <= '0;
							row_step_q <= '0;
						end else begin
							state_q <= ST_DIV_COL;
						end
					end
				end
				ST_DIV_COL: begin
					if (div_rsp.done) begin
						col_step_q <= div_rsp.quotient;
						state_q    <= ST_DIV_ROW;
					end
				end
				ST_DIV_ROW: begin
					if (div_rsp.done) begin
						row_step_q <= div_rsp.quotient;
						state_q    <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			res_q <= res_d;
		end
	end

	assign res       = res_q;
	assign res_empty = !res_valid_q;

`ifndef SYNTHESIS
	// Idle means nothing left to play, and playing means something left.
	a_idle_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == dtmf_pkg::MODE_IDLE) |-> (left_q == '0))
		else $error("samples left while idle");

	a_play_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != dtmf_pkg::MODE_IDLE) |-> (left_q != '0))
		else $error("tone or gap with no samples left");

	// A finished division only ever answers a step request.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_COL || state_q == ST_DIV_ROW))
		else $error("division finished outside a step computation");
`endif

endmodule

// File: dv/tb_dtmf_tone_generator_top.sv
// ----------------------------------------------------------------------------
// DTMF tone generator testbench
// Sends key and tick items through the queue ports of the tone generator. A
// scoreboard predicts each result from its own model of the keypad decode,
// the two table oscillators and the tone and gap timing. It then compares every
// popped result field by field. The sample rate changes between phases,
// including zero, tiny rates and the register extremes.
// ----------------------------------------------------------------------------
module tb_dtmf_tone_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_KEY       = 1'b0;
	localparam logic CMD_TICK      = 1'b1;
	localparam int   STALL_LIMIT   = 3000;
	localparam int   SETTLE_CYCLES = 64;

	// Keypad in scan order, first character in the top byte.
	localparam logic [8*16-1:0] DIAL_PAD = "123A456B789C*0#D";
	localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};
	localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
	localparam int unsigned TAYLOR [8] = '{272, 210, 156, 110, 72, 42, 20, 6};

	// Tracks the generator state and holds the results still due from the block.
	class dtmf_sample_scoreboard;
		logic [15:0]                    rate;
		logic [dtmf_pkg::PHASE_BITS-1:0] col_phase;
		logic [dtmf_pkg::PHASE_BITS-1:0] row_phase;
		logic [dtmf_pkg::PHASE_BITS-1:0] col_step;
		logic [dtmf_pkg::PHASE_BITS-1:0] row_step;
		logic [12:0]                    left;
		logic [1:0]                     mode;
		int                             sine [dtmf_pkg::PHASE_ENTRIES];
		dtmf_pkg::result_t              samples_due [$];
		int                             fails;

		function new();
			for (int i = 0; i < dtmf_pkg::PHASE_ENTRIES; i++) begin
				sine[i] = sine_entry(i);
			end
			rate      = 16'(dtmf_pkg::RATE_RESET);
			col_phase = '0;
			row_phase = '0;
			col_step  = '0;
			row_step  = '0;
			left      = '0;
			mode      = dtmf_pkg::MODE_IDLE;
			fails     = 0;
		endfunction

		// trunc(AMP * sin(2*pi*i/N)) in Q30, with the sine built by a nested
		// Taylor series on the quarter wave.
		function int sine_entry(int i);
			longint unsigned one;
			longint unsigned ang;
			longint unsigned sq;
			longint unsigned acc;
			longint unsigned s;
			int quad;
			int r;
			int mag;
			one  = 64'd1 << 30;
			quad = (4 * i) / dtmf_pkg::PHASE_ENTRIES;
			r    = 4 * i - quad * dtmf_pkg::PHASE_ENTRIES;
			if (quad % 2 == 1) begin
				r = dtmf_pkg::PHASE_ENTRIES - r;
			end
			if (r == 0) begin
				mag = 0;
			end else if (r >= dtmf_pkg::PHASE_ENTRIES) begin
				mag = dtmf_pkg::AMP;
			end else if (3 * r == dtmf_pkg::PHASE_ENTRIES) begin
				mag = dtmf_pkg::AMP / 2;
			end else begin
				ang = r;
				ang = (ang * 64'd1727108826179) / dtmf_pkg::PHASE_ENTRIES;
				ang = (ang + 64'd512) >> 10;
				sq  = (ang * ang) >> 30;
				acc = one;
				for (int k = 0; k < 8; k++) begin
					acc = one - ((sq * acc) >> 30) / TAYLOR[k];
				end
				s = (ang * acc) >> 30;
				if (s > one) begin
					s = one;
				end
				mag = int'((64'(dtmf_pkg::AMP) * s) >> 30);
			end
			return (quad >= 2) ? -mag : mag;
		endfunction

		// Phase step for one tone, kept modulo the table size.
		function logic [dtmf_pkg::PHASE_BITS-1:0] hz_to_step(int unsigned hz);
			if (rate == 0) begin
				return '0;
			end
			return dtmf_pkg::PHASE_BITS'((hz * dtmf_pkg::PHASE_ENTRIES) / rate);
		endfunction

		// The gap length is taken from the rate in force when the tone ends.
		function void start_gap();
			left = 13'(rate / 20);
			mode = (left != 0) ? dtmf_pkg::MODE_GAP : dtmf_pkg::MODE_IDLE;
		endfunction

		// Work out the result of one accepted item and queue it.
		function void note_item(logic cmd, logic [7:0] ch);
			dtmf_pkg::result_t res;
			logic [7:0] up;
			int pos;
			res = '0;
			if (cmd == CMD_KEY) begin
				up = ch;
				if (ch >= "a" && ch <= "z") begin
					up = ch - 8'h20;
				end
				pos = 16;
				for (int i = 0; i < 16; i++) begin
					if (DIAL_PAD[8*(15-i) +: 8] == up) begin
						pos = i;
					end
				end
				res.key_error = (pos == 16);
				res.key_busy  = (mode != dtmf_pkg::MODE_IDLE);
				if (!res.key_error && !res.key_busy) begin
					col_step  = hz_to_step(COL_HZ[pos % 4]);
					row_step  = hz_to_step(ROW_HZ[pos / 4]);
					col_phase = '0;
					row_phase = '0;
					left      = 13'(rate / 10);
					if (left != 0) begin
						mode = dtmf_pkg::MODE_TONE;
					end else begin
						start_gap();
					end
				end
			end else begin
				res.sample_valid = 1'b1;
				case (mode)
					dtmf_pkg::MODE_TONE: begin
						res.sample = 8'(sine[col_phase] + sine[row_phase] + dtmf_pkg::MID);
						col_phase  = col_phase + col_step;
						row_phase  = row_phase + row_step;
						left       = left - 1'b1;
						if (left == 0) begin
							start_gap();
						end
					end
					dtmf_pkg::MODE_GAP: begin
						left = left - 1'b1;
						if (left == 0) begin
							mode = dtmf_pkg::MODE_IDLE;
						end
					end
					default: begin
						mode = dtmf_pkg::MODE_IDLE;
					end
				endcase
			end
			res.active = (mode != dtmf_pkg::MODE_IDLE);
			samples_due.push_back(res);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want,
					got);
				fails++;
			end
		endfunction

		// Compare one popped result with the oldest prediction.
		function void check_item(dtmf_pkg::result_t got);
			dtmf_pkg::result_t want;
			if (samples_due.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h", $time,
					got);
				fails++;
			end else begin
				want = samples_due.pop_front();
				compare("sample", want.sample, got.sample);
				compare("sample_valid", want.sample_valid, got.sample_valid);
				compare("key_error", want.key_error, got.key_error);
				compare("key_busy", want.key_busy, got.key_busy);
				compare("active", want.active, got.active);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        command     = 1'b0;
	logic [7:0]  key_char    = 8'h00;
	logic        pop         = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        full;
	logic        empty;
	logic [7:0]  sample;
	logic        sample_valid;
	logic        key_error;
	logic        key_busy;
	logic        active;

	int send_idle_pct = 7;
	int recv_idle_pct = 59;
	int recv_hold     = 0;

	dtmf_sample_scoreboard sb;

	dtmf_tone_generator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.key_char     (key_char),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample),
		.sample_valid (sample_valid),
		.key_error    (key_error),
		.key_busy     (key_busy),
		.active       (active),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one item, with random idle cycles ahead of it, until it is taken.
	task automatic send_item(input logic cmd, input logic [7:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		command  <= cmd;
		key_char <= ch;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		sb.note_item(cmd, ch);
	endtask

	// Mostly ticks and dial keys in either case, with some arbitrary characters.
	task automatic send_random_item();
		int pick;
		int pos;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		pos  = $urandom_range(0, 15);
		ch   = DIAL_PAD[8*(15-pos) +: 8];
		if (pick < 65) begin
			send_item(CMD_TICK, 8'($urandom));
		end else if (pick < 88) begin
			if (ch >= "A" && $urandom_range(0, 1) == 1) begin
				ch = ch + 8'h20;
			end
			send_item(CMD_KEY, ch);
		end else begin
			send_item(CMD_KEY, 8'($urandom));
		end
	endtask

	// Rate writes wait until all results are back and the divider has settled.
	task automatic write_rate(input logic [15:0] value);
		push <= 1'b0;
		while (sb.samples_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.rate = value;
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: check every popped item, then pick the next pop value.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				sb.check_item({sample, sample_valid, key_error, key_busy, active});
			end
			if (recv_hold > 0) begin
				recv_hold--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without any item moving ends the run.
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("tb_dtmf_tone_generator_top failed");
		$finish;
	end

	initial begin
		int rate_pick;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick and characters off the keypad at the reset rate.
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_KEY, 8'h00);
		send_item(CMD_KEY, 8'hFF);
		// Zero rate: a valid key leaves the block idle.
		write_rate(16'd0);
		send_item(CMD_KEY, "1");
		send_item(CMD_TICK, 8'hFF);
		// Zero tone and gap length.
		write_rate(16'd5);
		send_item(CMD_KEY, "D");
		// One-sample tone with no gap; keys while busy, one also off the keypad.
		write_rate(16'd15);
		send_item(CMD_KEY, "a");
		send_item(CMD_KEY, "#");
		send_item(CMD_KEY, "q");
		send_item(CMD_TICK, 8'h55);
		// Steps far above the table size, then a rate change in the middle of a tone.
		write_rate(16'd40);
		send_item(CMD_KEY, "*");
		send_item(CMD_TICK, 8'hAA);
		send_item(CMD_TICK, 8'h00);
		write_rate(16'd200);
		repeat (4) send_item(CMD_TICK, 8'h0F);

		// Random phases at short tone lengths so that many tones finish.
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 59 : 0;
			recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 7 : 0;
			case (ph)
				0: rate_pick = $urandom_range(20, 60);
				1: rate_pick = $urandom_range(100, 400);
				2: rate_pick = $urandom_range(10, 30);
				3: rate_pick = $urandom_range(40, 200);
				4: rate_pick = $urandom_range(200, 600);
				default: rate_pick = $urandom_range(20, 120);
			endcase
			write_rate(16'(rate_pick));
			// Hold the result side off long enough for the input to fill.
			if (ph == 1) begin
				recv_hold = 80;
			end
			repeat (65) send_random_item();
		end

		// Play out the current tone so the next key starts one.
		while (sb.mode != dtmf_pkg::MODE_IDLE) begin
			send_item(CMD_TICK, 8'($urandom));
		end

		// Register extremes: start at the top rate, change it during the tone.
		write_rate(16'hFFFF);
		send_item(CMD_KEY, DIAL_PAD[8*(15-$urandom_range(0, 15)) +: 8]);
		repeat (20) send_item(CMD_TICK, 8'($urandom));
		write_rate(16'd48000);
		repeat (10) send_item(CMD_TICK, 8'($urandom));
		write_rate(16'd4000);
		repeat (5) send_item(CMD_TICK, 8'($urandom));
		push <= 1'b0;

		while (sb.samples_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.samples_due.size() == 0) begin
			$display("tb_dtmf_tone_generator_top passed");
		end else begin
			$display("tb_dtmf_tone_generator_top failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/dtmf_pkg.sv
rtl/core/dtmf_front.sv
rtl/core/dtmf_cmd_fifo.sv
rtl/core/dtmf_divider.sv
rtl/core/dtmf_back.sv
rtl/core/dtmf_tone_generator_top.sv
dv/tb_dtmf_tone_generator_top.sv
